// ----- rtl/bstk_pkg.sv -----
// Package for the bounded order stack: word types, record type, operation and
// status codes, and the control bundle that drives the cell chain.
// No dependencies.
package bstk_pkg;

    localparam int DEPTH_DEFAULT = 16;

    typedef enum logic [1:0] {
        FUNC_PUSH   = 2'd0,
        FUNC_POP    = 2'd1,
        FUNC_SEARCH = 2'd2,
        FUNC_REMOVE = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_EMPTY     = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_t;

    typedef struct packed {
        func_t       func;
        logic [15:0] order_id;
        logic [15:0] distance_in;
        logic [15:0] value_in;
        logic [7:0]  product_in;
    } req_word_t;

    typedef struct packed {
        status_t     status;
        logic [3:0]  found_index;
        logic [15:0] id_out;
        logic [15:0] distance_out;
        logic [15:0] value_out;
        logic [7:0]  product_out;
        logic [4:0]  depth_after;
    } rsp_word_t;

    typedef struct packed {
        logic [15:0] id;
        logic [15:0] distance;
        logic [15:0] value;
        logic [7:0]  product;
    } rec_t;

    typedef struct packed {
        logic        cap_hit;
        logic        push_en;
        logic        remove_en;
        logic [15:0] key;
        rec_t        push_rec;
    } cell_ctl_t;

endpackage

// ----- rtl/bstk_cell.sv -----
// One storage cell of the order stack chain: holds one record and its match flag.
// Depends on bstk_pkg.
module bstk_cell
    import bstk_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int INDEX = 0,
    localparam int CW = $clog2(DEPTH + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  cell_ctl_t     ctl,
    input  logic [CW-1:0] count,
    input  logic          at_or_above_hit,
    input  rec_t          upper_rec,
    output rec_t          rec,
    output logic          hit
);

    rec_t rec_reg;
    rec_t rec_next;
    logic hit_reg;
    logic occupied;

    assign occupied = count > CW'(INDEX);

    always_comb
    begin
        rec_next = rec_reg;
        if (ctl.push_en && count == CW'(INDEX))
        begin
            rec_next = ctl.push_rec;
        end
        else if (ctl.remove_en && at_or_above_hit && count > CW'(INDEX + 1))
        begin
            rec_next = upper_rec;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (ctl.cap_hit)
        begin
            hit_reg <= occupied && (rec_reg.id == ctl.key);
        end
    end

    assign rec = rec_reg;
    assign hit = hit_reg;

endmodule

// ----- rtl/bounded_stack_with_key_removal.sv -----
// Bounded LIFO stack of order records with search and removal by id.
// Push and pop go from acceptance straight to the done state; search and
// remove first capture match flags in the cell chain, pick the lowest match,
// then read out and shift the chain down one cell in one step. The result
// word is registered; a new request is taken only once the last one is done.
// Reset: the entry count clears to zero; the cell records are not cleared.
module bounded_stack_with_key_removal
    import bstk_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_word_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_word_t rsp
);

    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_PICK,
        S_DONE
    } state_t;

    state_t          state_reg;
    req_word_t       op_reg;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic [DEPTH-1:0] onehot_reg;
    logic [DEPTH-1:0] ge_reg;
    rsp_word_t       rsp_reg;
    rsp_word_t       rsp_next;
    logic            rsp_valid_reg;

    rec_t            rec_arr [DEPTH];
    logic [DEPTH-1:0] hit_vec;
    logic [DEPTH-1:0] sel_vec;
    rec_t            sel_rec;
    logic [CW-1:0]   hit_idx;
    cell_ctl_t       ctl;
    logic            req_fire;
    logic            done_fire;
    logic            full;
    logic            empty;
    logic            miss;

    assign req_ready = (state_reg == S_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign done_fire = (state_reg == S_DONE) && (!rsp_valid_reg || rsp_ready);

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign miss  = (onehot_reg == '0);

    always_comb
    begin
        sel_vec = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (op_reg.func == FUNC_POP)
            begin
                sel_vec[i] = (count_reg == CW'(i + 1));
            end
            else if (op_reg.func == FUNC_REMOVE)
            begin
                sel_vec[i] = onehot_reg[i];
            end
        end
    end

    always_comb
    begin
        sel_rec = '0;
        hit_idx = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (sel_vec[i])
            begin
                sel_rec = sel_rec | rec_arr[i];
            end
            if (onehot_reg[i])
            begin
                hit_idx = hit_idx | CW'(i);
            end
        end
    end

    always_comb
    begin
        ctl.cap_hit          = (state_reg == S_MATCH);
        ctl.push_en          = 1'b0;
        ctl.remove_en        = 1'b0;
        ctl.key              = op_reg.order_id;
        ctl.push_rec.id       = op_reg.order_id;
        ctl.push_rec.distance = op_reg.distance_in;
        ctl.push_rec.value    = op_reg.value_in;
        ctl.push_rec.product  = op_reg.product_in;
        count_next = count_reg;
        rsp_next   = '0;
        unique case (op_reg.func)
            FUNC_PUSH:
            begin
                if (full)
                begin
                    rsp_next.status = STAT_FULL;
                end
                else
                begin
                    ctl.push_en = done_fire;
                    count_next  = count_reg + CW'(1);
                end
            end
            FUNC_POP:
            begin
                if (empty)
                begin
                    rsp_next.status = STAT_EMPTY;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            FUNC_SEARCH:
            begin
                if (miss)
                begin
                    rsp_next.status = STAT_NOT_FOUND;
                end
                else
                begin
                    rsp_next.found_index = 4'(hit_idx);
                end
            end
            FUNC_REMOVE:
            begin
                if (miss)
                begin
                    rsp_next.status = STAT_NOT_FOUND;
                end
                else
                begin
                    ctl.remove_en = done_fire;
                    count_next    = count_reg - CW'(1);
                end
            end
            default:
            begin
                rsp_next = '0;
            end
        endcase
        rsp_next.id_out       = sel_rec.id;
        rsp_next.distance_out = sel_rec.distance;
        rsp_next.value_out    = sel_rec.value;
        rsp_next.product_out  = sel_rec.product;
        rsp_next.depth_after  = 5'(count_next);
    end

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        rec_t upper;
        if (g == DEPTH - 1)
        begin : g_last
            assign upper = rec_arr[g];
        end
        else
        begin : g_mid
            assign upper = rec_arr[g + 1];
        end

        bstk_cell #(
            .DEPTH (DEPTH),
            .INDEX (g)
        ) u_cell (
            .clk             (clk),
            .rst_n           (rst_n),
            .ctl             (ctl),
            .count           (count_reg),
            .at_or_above_hit (ge_reg[g]),
            .upper_rec       (upper),
            .rec             (rec_arr[g]),
            .hit             (hit_vec[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            onehot_reg    <= '0;
            ge_reg        <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_fire)
                    begin
                        if (req.func == FUNC_SEARCH || req.func == FUNC_REMOVE)
                        begin
                            state_reg <= S_MATCH;
                        end
                        else
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_MATCH:
                begin
                    state_reg <= S_PICK;
                end
                S_PICK:
                begin
                    // isolate lowest match, and mark it with every cell above
                    onehot_reg <= hit_vec & (~hit_vec + DEPTH'(1));
                    ge_reg     <= hit_vec | (~hit_vec + DEPTH'(1));
                    state_reg  <= S_DONE;
                end
                S_DONE:
                begin
                    if (done_fire)
                    begin
                        count_reg  <= count_next;
                        onehot_reg <= '0;
                        ge_reg     <= '0;
                        state_reg  <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (done_fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            op_reg <= req;
        end
        if (done_fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_pick_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(onehot_reg) && ((onehot_reg & ~ge_reg) == '0))
        else $error("lowest match select malformed");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        done_fire && op_reg.func == FUNC_PUSH && !full
        |=> count_reg == $past(count_reg + CW'(1)))
        else $error("push did not grow the stack");

    a_depth_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> rsp_reg.depth_after == 5'(count_reg))
        else $error("reported depth differs from held count");

endmodule
